### src/mvt_pkg.sv
// ----------------------------------------------------------------------------
// mvt_pkg - shared types and constants for the 4x4 matrix vector transform
// Fixed-point format, operation codes and derived datapath widths.
// ----------------------------------------------------------------------------
package mvt_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;

	// Product and accumulation widths
	localparam int PROD_W = 2 * DATA_W;
	localparam int PAIR_W = PROD_W + 1;
	localparam int SUM_W  = PROD_W + 3;

	// Small-vector test: a component of magnitude 2^(FRAC_BITS-1) or more
	// already squares past the limit, so only narrow magnitudes are squared.
	localparam int SQ_MAG_W = FRAC_BITS - 1;
	localparam int SQ_W     = 2 * SQ_MAG_W;
	localparam int SQ_SUM_W = SQ_W + 2;
	localparam logic [63:0] SMALL_LIMIT = ((64'd1 << (2 * FRAC_BITS)) + 64'd9) / 64'd10;

	typedef logic signed [DATA_W-1:0] word_t;
	typedef word_t quad_t [4];

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_XFORM4 = 2'd1,
		OP_XFORM3 = 2'd2
	} op_t;

	localparam word_t ONE_Q    = {{(DATA_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
	localparam word_t WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	localparam logic signed [SUM_W-1:0] ROUND_BIAS =
		{{(SUM_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

endpackage

### src/mvt_lane.sv
// ----------------------------------------------------------------------------
// mvt_lane - one row dot product lane
// Four multipliers, a pairwise add, a final add with rounding, saturation.
// ----------------------------------------------------------------------------
module mvt_lane (
	input  logic          clk,
	input  logic          adv,
	input  mvt_pkg::quad_t mat_row,
	input  mvt_pkg::quad_t vec,
	output mvt_pkg::word_t dot
);
	import mvt_pkg::*;

	logic signed [PROD_W-1:0] prod_s1 [4];
	logic signed [PAIR_W-1:0] pair_s2 [2];
	logic signed [SUM_W-1:0]  sum_s3;
	logic [SUM_W-FRAC_BITS-DATA_W:0] head;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 4; c++) begin
				prod_s1[c] <= mat_row[c] * vec[c];
			end
			pair_s2[0] <= PAIR_W'(prod_s1[0]) + PAIR_W'(prod_s1[1]);
			pair_s2[1] <= PAIR_W'(prod_s1[2]) + PAIR_W'(prod_s1[3]);
			sum_s3     <= SUM_W'(pair_s2[0]) + SUM_W'(pair_s2[1]) + ROUND_BIAS;
		end
	end

	// Drop the fraction, clamp when the integer part leaves the word range
	assign head = sum_s3[SUM_W-1:FRAC_BITS+DATA_W-1];

	always_comb begin
		if (head == '0 || head == '1) begin
			dot = sum_s3[FRAC_BITS+DATA_W-1:FRAC_BITS];
		end else if (sum_s3[SUM_W-1]) begin
			dot = WORD_MIN;
		end else begin
			dot = WORD_MAX;
		end
	end

endmodule

### src/mvt_norm.sv
// ----------------------------------------------------------------------------
// mvt_norm - small-vector detector
// Flags x*x + y*y + z*z below 0.1; the squares are registered, then the flag.
// ----------------------------------------------------------------------------
module mvt_norm (
	input  logic           clk,
	input  logic           adv,
	input  mvt_pkg::word_t vx,
	input  mvt_pkg::word_t vy,
	input  mvt_pkg::word_t vz,
	output logic           small_s2
);
	import mvt_pkg::*;

	word_t                comp [3];
	word_t                neg  [3];
	logic                 fits [3];
	logic [SQ_MAG_W-1:0]  mag  [3];
	logic [DATA_W-SQ_MAG_W-1:0] hi [3];

	logic [SQ_W-1:0]      sq_s1   [3];
	logic                 fits_s1 [3];
	logic [SQ_SUM_W-1:0]  sq_sum;

	assign comp[0] = vx;
	assign comp[1] = vy;
	assign comp[2] = vz;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			neg[i]  = -comp[i];
			hi[i]   = comp[i][DATA_W-1:SQ_MAG_W];
			fits[i] = (hi[i] == '0) || (hi[i] == '1 && comp[i][SQ_MAG_W-1:0] != '0);
			mag[i]  = comp[i][DATA_W-1] ? neg[i][SQ_MAG_W-1:0] : comp[i][SQ_MAG_W-1:0];
		end
	end

	assign sq_sum = SQ_SUM_W'(sq_s1[0]) + SQ_SUM_W'(sq_s1[1]) + SQ_SUM_W'(sq_s1[2]);

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sq_s1[i]   <= mag[i] * mag[i];
				fits_s1[i] <= fits[i];
			end
			small_s2 <= fits_s1[0] && fits_s1[1] && fits_s1[2] &&
				(64'(sq_sum) < SMALL_LIMIT);
		end
	end

endmodule

### src/matrix_vector_transform_4x4.sv
// ----------------------------------------------------------------------------
// matrix_vector_transform_4x4 - 4x4 Q16.16 matrix by vector, four row lanes
// A transform word passes the product, pair and sum stages, then the output register.
// One word per cycle, write or transform, while in_stall stays low.
// Reset clears the matrix to zero and empties the pipe and the skid stage.
// ----------------------------------------------------------------------------
module matrix_vector_transform_4x4 (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [1:0]     operation,
	input  logic [1:0]     row_index,
	input  logic [1:0]     col_index,
	input  mvt_pkg::word_t element_value,
	input  mvt_pkg::word_t vec_x,
	input  mvt_pkg::word_t vec_y,
	input  mvt_pkg::word_t vec_z,
	input  mvt_pkg::word_t vec_w,
	output logic           out_valid,
	input  logic           out_stall,
	output mvt_pkg::word_t out_x,
	output mvt_pkg::word_t out_y,
	output mvt_pkg::word_t out_z,
	output mvt_pkg::word_t out_w
);
	import mvt_pkg::*;

	// Matrix storage, row * 4 + column
	word_t matrix_q [16];
	quad_t rows     [4];
	quad_t vec_in;

	// Pipe control: the whole pipe moves unless the skid stage is holding a word
	logic  adv;
	logic  in_acc;
	logic  is_xform;
	logic  valid_s1, valid_s2, valid_s3;
	logic  xf3_s1, xf3_s2, xf3_s3;
	logic  small_s2, small_s3;

	word_t lane_dot [4];
	quad_t merged;

	// Output register plus one skid entry
	logic  out_valid_q;
	logic  skid_valid_q;
	quad_t out_q;
	quad_t skid_q;
	logic  push;
	logic  pop;

	assign adv      = !skid_valid_q;
	assign in_stall = skid_valid_q;
	assign in_acc   = in_valid && adv;
	assign is_xform = (operation == OP_XFORM4) || (operation == OP_XFORM3);

	// Load one matrix entry per write word; transforms in flight already hold
	// their products, so a later write never disturbs them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				matrix_q[i] <= '0;
			end
		end else if (in_acc && operation == OP_WRITE) begin
			matrix_q[{row_index, col_index}] <= element_value;
		end
	end

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				rows[r][c] = matrix_q[4'(r*4 + c)];
			end
		end
	end

	// Three-component points carry an implied w of one
	assign vec_in[0] = vec_x;
	assign vec_in[1] = vec_y;
	assign vec_in[2] = vec_z;
	assign vec_in[3] = (operation == OP_XFORM3) ? ONE_Q : vec_w;

	for (genvar r = 0; r < 4; r++) begin : g_lane
		mvt_lane u_lane (
			.clk     (clk),
			.adv     (adv),
			.mat_row (rows[r]),
			.vec     (vec_in),
			.dot     (lane_dot[r])
		);
	end

	mvt_norm u_norm (
		.clk      (clk),
		.adv      (adv),
		.vx       (vec_x),
		.vy       (vec_y),
		.vz       (vec_z),
		.small_s2 (small_s2)
	);

	// Only transform words travel down the pipe; writes and the unused code drop here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_acc && is_xform;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xf3_s1   <= (operation == OP_XFORM3);
			xf3_s2   <= xf3_s1;
			xf3_s3   <= xf3_s2;
			small_s3 <= small_s2;
		end
	end

	// Merge lanes: a small point zeroes everything, a point always zeroes w
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			merged[r] = (xf3_s3 && small_s3) ? '0 : lane_dot[r];
		end
		if (xf3_s3) begin
			merged[3] = '0;
		end
	end

	assign push = valid_s3 && adv;
	assign pop  = out_valid_q && !out_stall;

	// Refill the output register from the skid entry first, else from the pipe;
	// park a new word in the skid entry while the output is held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_q <= skid_valid_q ? skid_q : merged;
		end else if (push) begin
			skid_q <= merged;
		end
	end

	assign out_valid = out_valid_q;
	assign out_x     = out_q[0];
	assign out_y     = out_q[1];
	assign out_z     = out_q[2];
	assign out_w     = out_q[3];

`ifndef SYNTH
	// A word sits in the skid entry only behind a held output word
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry full while output register empty");

	// The skid entry fills only when the output was held by the consumer
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && out_stall))
		else $error("skid entry filled without a stalled output");

	// An accepted write lands in the addressed matrix entry
	a_matrix_write: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && operation == OP_WRITE) |=>
		matrix_q[$past({row_index, col_index})] == $past(element_value))
		else $error("matrix write lost");

	// A three-component result loaded straight from the pipe into the output has a zero w
	a_point_w_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(push && xf3_s3 && (!out_valid_q || pop) && !skid_valid_q) |=> out_q[3] == '0)
		else $error("point transform produced nonzero w");
`endif

endmodule

### dv/matrix_vector_transform_4x4_tb.sv
// ----------------------------------------------------------------------------
// matrix_vector_transform_4x4_tb - self-checking bench for the 4x4 transform
// Loads the matrix through write words, sends four- and three-component
// transform words and checks every result word against a cycle-free
// predictor of the matrix product with round-to-nearest and saturation.
// ----------------------------------------------------------------------------
module matrix_vector_transform_4x4_tb;

	import mvt_pkg::*;

	// Operation code the block must ignore (no result, matrix unchanged)
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int FRAC         = FRAC_BITS;
	localparam int RANDOM_WORDS = 800;
	localparam int TAIL_WORDS   = 100;     // last words sent with no idling
	localparam int HOLD_AT      = 250;     // accepted words before the long hold-off
	localparam int HOLD_CYCLES  = 60;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int REPORT_MAX   = 10;

	// Wide enough for the exact sum of four 32x32 products plus rounding
	typedef logic signed [67:0] acc_t;

	localparam acc_t ROUND_HALF  = acc_t'(1) <<< (FRAC - 1);
	localparam acc_t SHORT_LIMIT = ((acc_t'(1) <<< (2 * FRAC)) + 9) / 10;

	typedef struct {
		logic [1:0] op;
		logic [1:0] row;
		logic [1:0] col;
		word_t      elem;
		word_t      x;
		word_t      y;
		word_t      z;
		word_t      w;
	} xform_word_t;

	typedef struct {
		word_t x;
		word_t y;
		word_t z;
		word_t w;
	} quad_result_t;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       in_valid      = 1'b0;
	logic       in_stall;
	logic [1:0] operation     = OP_WRITE;
	logic [1:0] row_index     = '0;
	logic [1:0] col_index     = '0;
	word_t      element_value = '0;
	word_t      vec_x         = '0;
	word_t      vec_y         = '0;
	word_t      vec_z         = '0;
	word_t      vec_w         = '0;
	logic       out_valid;
	logic       out_stall     = 1'b0;
	word_t      out_x;
	word_t      out_y;
	word_t      out_z;
	word_t      out_w;

	xform_word_t  pending_words[$];
	quad_result_t expected_results[$];
	word_t        model_matrix[16];

	logic word_taken     = 1'b0;
	int   words_accepted = 0;
	int   results_seen   = 0;
	int   fail_count     = 0;
	int   send_gap       = 0;
	int   recv_gap       = 0;
	int   hold_left      = 0;
	logic hold_done      = 1'b0;
	int   cycle_count    = 0;

	matrix_vector_transform_4x4 dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.row_index     (row_index),
		.col_index     (col_index),
		.element_value (element_value),
		.vec_x         (vec_x),
		.vec_y         (vec_y),
		.vec_z         (vec_z),
		.vec_w         (vec_w),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_x         (out_x),
		.out_y         (out_y),
		.out_z         (out_z),
		.out_w         (out_w)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Dot one matrix row with the vector, round half up, clamp to 32 bits.
	function automatic word_t row_dot(int unsigned row, acc_t v0, acc_t v1, acc_t v2,
			acc_t v3);
		acc_t sum;
		sum = acc_t'(model_matrix[row * 4 + 0]) * v0
			+ acc_t'(model_matrix[row * 4 + 1]) * v1
			+ acc_t'(model_matrix[row * 4 + 2]) * v2
			+ acc_t'(model_matrix[row * 4 + 3]) * v3;
		sum = (sum + ROUND_HALF) >>> FRAC;
		if (sum > acc_t'(WORD_MAX))
			return WORD_MAX;
		if (sum < acc_t'(WORD_MIN))
			return WORD_MIN;
		return sum[DATA_W-1:0];
	endfunction

	function automatic quad_result_t transform_result(logic [1:0] op, word_t x, word_t y,
			word_t z, word_t w);
		quad_result_t q;
		acc_t         mag;
		q = '{'0, '0, '0, '0};
		if (op == OP_XFORM4) begin
			q.x = row_dot(0, x, y, z, w);
			q.y = row_dot(1, x, y, z, w);
			q.z = row_dot(2, x, y, z, w);
			q.w = row_dot(3, x, y, z, w);
		end else begin
			// Three-component point: w is one, row 3 unused; tiny points give zero
			mag = acc_t'(x) * acc_t'(x) + acc_t'(y) * acc_t'(y) + acc_t'(z) * acc_t'(z);
			if (mag >= SHORT_LIMIT) begin
				q.x = row_dot(0, x, y, z, ONE_Q);
				q.y = row_dot(1, x, y, z, ONE_Q);
				q.z = row_dot(2, x, y, z, ONE_Q);
			end
		end
		return q;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Draw a Q16.16 value: full range, near unity, extremes, tiny or moderate.
	function automatic word_t pick_q16();
		case ($urandom_range(0, 5))
			0: return word_t'($urandom);
			1: return word_t'($urandom_range(0, 8 * 65536)) - 4 * ONE_Q;
			2: begin
				case ($urandom_range(0, 6))
					0: return WORD_MAX;
					1: return WORD_MIN;
					2: return '0;
					3: return ONE_Q;
					4: return -ONE_Q;
					5: return word_t'(1);
					default: return word_t'(-1);
				endcase
			end
			3: return word_t'($urandom_range(0, 40000)) - word_t'(20000);
			default: return word_t'($urandom_range(0, 32'h00FF_FFFF)) - word_t'(32'h0080_0000);
		endcase
	endfunction

	// Fill every field at random, including the ones the operation ignores.
	function automatic xform_word_t random_word(logic [1:0] op);
		xform_word_t t;
		t.op   = op;
		t.row  = 2'($urandom);
		t.col  = 2'($urandom);
		t.elem = pick_q16();
		t.x    = pick_q16();
		t.y    = pick_q16();
		t.z    = pick_q16();
		t.w    = pick_q16();
		return t;
	endfunction

	function automatic xform_word_t vector_word(logic [1:0] op, word_t x, word_t y, word_t z,
			word_t w);
		xform_word_t t;
		t   = random_word(op);
		t.x = x;
		t.y = y;
		t.z = z;
		t.w = w;
		return t;
	endfunction

	// Append one word to the send queue
	task automatic queue_word(input xform_word_t t);
		pending_words = {pending_words, t};
	endtask

	// ------------------------------------------------------------------
	// Sequence: reset, directed words, random words, drain, verdict
	// ------------------------------------------------------------------
	initial begin
		xform_word_t t;
		word_t       seed_matrix[16];
		int          pick;

		// Row 0 and row 3 hold the extremes so both clamps and the widest sum
		// (four products of the most negative value) are exercised.
		seed_matrix = '{WORD_MAX, WORD_MIN, '0, ONE_Q,
			word_t'(1), ONE_Q, word_t'(-1), -ONE_Q,
			word_t'(32'h0000_8000), -word_t'(32'h0000_8000), ONE_Q, '0,
			WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN};

		// Transform against the cleared matrix first
		queue_word(vector_word(OP_XFORM4, WORD_MAX, WORD_MIN, ONE_Q, word_t'(-1)));

		for (int i = 0; i < 16; i++) begin
			t      = random_word(OP_WRITE);
			t.row  = 2'(i / 4);
			t.col  = 2'(i % 4);
			t.elem = seed_matrix[i];
			queue_word(t);
		end

		queue_word(vector_word(OP_XFORM4, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
		queue_word(vector_word(OP_XFORM4, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
		queue_word(vector_word(OP_XFORM4, WORD_MAX, WORD_MIN, ONE_Q, word_t'(-1)));
		// Rounding tie: half an LSB after the scale-down
		queue_word(vector_word(OP_XFORM4, word_t'(32'h0000_8000), word_t'(1),
			word_t'(-1), '0));
		// Zero point, a point just inside and one just outside the small-vector test
		queue_word(vector_word(OP_XFORM3, '0, '0, '0, pick_q16()));
		queue_word(vector_word(OP_XFORM3, word_t'(20724), '0, '0, pick_q16()));
		queue_word(vector_word(OP_XFORM3, '0, word_t'(-20725), '0, pick_q16()));
		queue_word(vector_word(OP_XFORM3, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX));
		// Unused operation code must be dropped silently
		queue_word(random_word(OP_UNUSED));

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 15)
				t = random_word(OP_WRITE);
			else if (pick < 57)
				t = random_word(OP_XFORM4);
			else
				t = random_word(OP_XFORM3);
			// Points around the small-vector threshold
			if (t.op == OP_XFORM3 && $urandom_range(0, 3) == 0) begin
				t.x = word_t'($urandom_range(0, 26000)) - word_t'(13000);
				t.y = word_t'($urandom_range(0, 26000)) - word_t'(13000);
				t.z = word_t'($urandom_range(0, 26000)) - word_t'(13000);
			end
			queue_word(t);
			if ($urandom_range(0, 39) == 0)
				queue_word(random_word(OP_UNUSED));
		end

		// Hold reset, then release it at a falling edge, away from the rising edge
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// ------------------------------------------------------------------
	// Driver: present the next word at the falling edge once the current
	// one is taken; hold a stalled word untouched.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		xform_word_t t;
		logic        valid_next;
		if (arst_n) begin
			valid_next = in_valid;
			if (!in_valid || word_taken) begin
				valid_next = 1'b0;
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
				end else if (pending_words.size() >= TAIL_WORDS && hold_left == 0
						&& $urandom_range(0, 7) == 0) begin
					// Idle now and for a random gap counted down in send_gap
					send_gap <= $urandom_range(1, 11) - 1;
				end else if (pending_words.size() > 0) begin
					t             = pending_words.pop_front();
					operation     <= t.op;
					row_index     <= t.row;
					col_index     <= t.col;
					element_value <= t.elem;
					vec_x         <= t.x;
					vec_y         <= t.y;
					vec_z         <= t.z;
					vec_w         <= t.w;
					valid_next    = 1'b1;
				end
			end
			in_valid <= valid_next;
		end
	end

	// ------------------------------------------------------------------
	// Receiver stall: random bursts, plus one long hold-off so the pipe
	// backs up into in_stall while the driver keeps offering words.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		logic stall_next;
		if (arst_n) begin
			stall_next = 1'b0;
			if (hold_left > 0) begin
				hold_left  <= hold_left - 1;
				stall_next = 1'b1;
			end else if (!hold_done && words_accepted >= HOLD_AT) begin
				hold_done  <= 1'b1;
				hold_left  <= HOLD_CYCLES - 1;
				stall_next = 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap   <= recv_gap - 1;
				stall_next = 1'b1;
			end else if (pending_words.size() >= TAIL_WORDS && $urandom_range(0, 7) == 0) begin
				recv_gap   <= $urandom_range(1, 11) - 1;
				stall_next = 1'b1;
			end
			out_stall <= stall_next;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: update the predictor with each accepted input word, then
	// compare each accepted result word with the oldest expectation.
	// ------------------------------------------------------------------
	function automatic void note_mismatch(string field, word_t want, word_t got);
		if (fail_count < REPORT_MAX)
			$display("result %0d: %s mismatch, expected %h got %h", results_seen, field,
				want, got);
		fail_count++;
	endfunction

	always @(posedge clk) begin
		quad_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < 16; i++)
				model_matrix[i] = '0;
		end else begin
			word_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				words_accepted <= words_accepted + 1;
				case (operation)
					OP_WRITE: model_matrix[{row_index, col_index}] = element_value;
					OP_XFORM4, OP_XFORM3:
						expected_results = {expected_results,
							transform_result(operation, vec_x, vec_y, vec_z, vec_w)};
					default: ;  // drop the unused code
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					if (fail_count < REPORT_MAX)
						$display("result %0d: unexpected word %h %h %h %h", results_seen,
							out_x, out_y, out_z, out_w);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (out_x !== want.x)
						note_mismatch("out_x", want.x, out_x);
					if (out_y !== want.y)
						note_mismatch("out_y", want.y, out_y);
					if (out_z !== want.z)
						note_mismatch("out_z", want.z, out_z);
					if (out_w !== want.w)
						note_mismatch("out_w", want.w, out_w);
				end
				results_seen++;
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule
